// ===== sv/hasynth_pkg.sv =====
package hasynth_pkg;

  localparam int HARMONICS       = 12;
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;

  localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
  localparam int QUARTER         = 1 << QUARTER_BITS;
  localparam int FULL_SCALE      = 32767;

  localparam int AMP_BITS        = 15;
  localparam int AMP_FIELD_BITS  = 16;
  localparam int AMP_PER_REG     = 4;
  localparam int SAMPLE_BITS     = 16;
  localparam int SUM_BITS        = SAMPLE_BITS + $clog2(HARMONICS + 1);
  localparam int COUNT_BITS      = 4;
  localparam int CFG_DATA_BITS   = 64;
  localparam int CFG_IDX_BITS    = 3;

  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PHASE_STEP     = 3'd0,
    REG_HARMONIC_COUNT = 3'd1,
    REG_WEIGHTS_LO     = 3'd2,
    REG_WEIGHTS_MID    = 3'd3,
    REG_WEIGHTS_HI     = 3'd4
  } cfg_reg_e;

  typedef logic [PHASE_BITS-1:0] phase_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]                 n;
    logic [HARMONICS-1:0][AMP_BITS-1:0]    amp;
  } synth_cfg_t;

  typedef struct packed {
    logic                          valid;
    phase_t                        phase;
    phase_t                        hphase;
    logic signed [SUM_BITS-1:0]    sum;
    logic signed [SAMPLE_BITS-1:0] part;
  } cell_t;

  typedef logic [AMP_BITS-1:0] sine_rom_t [0:QUARTER];

  // quarter wave, odd polynomial through x^9 with q30 coefficients
  function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    for (int i = 0; i <= QUARTER; i++) begin
      u   = 64'(i) << (30 - QUARTER_BITS);
      u2  = mul_q30(u, u);
      t   = 64'd5026995 - mul_q30(u2, 64'd172272);
      t   = 64'd85569306 - mul_q30(u2, t);
      t   = 64'd693598668 - mul_q30(u2, t);
      t   = 64'd1686629713 - mul_q30(u2, t);
      s   = mul_q30(u, t);
      mag = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
      if (mag > 64'(FULL_SCALE)) begin
        mag = 64'(FULL_SCALE);
      end
      rom[i] = mag[AMP_BITS-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== sv/hasynth_front.sv =====
module hasynth_front (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [hasynth_pkg::CFG_IDX_BITS-1:0]        cfg_idx_i,
  input  logic [hasynth_pkg::CFG_DATA_BITS-1:0]       cfg_wdata_i,
  input  logic                                        in_valid_i,
  output logic                                        in_stall_o,
  input  logic                                        restart_i,
  input  logic                                        q_full_i,
  output logic                                        push_o,
  output hasynth_pkg::phase_t                         push_phase_o,
  output hasynth_pkg::synth_cfg_t                     cfg_o
);

  hasynth_pkg::phase_t                                        phase_q, phase_d;
  hasynth_pkg::phase_t                                        step_q;
  logic [hasynth_pkg::COUNT_BITS-1:0]                         count_q;
  logic [hasynth_pkg::HARMONICS-1:0][hasynth_pkg::AMP_BITS-1:0] amp_q;
  hasynth_pkg::phase_t                                        phase_cur;

  assign in_stall_o   = q_full_i;
  assign push_o       = in_valid_i && !q_full_i;
  assign phase_cur    = restart_i ? '0 : phase_q;
  assign push_phase_o = phase_cur;
  assign phase_d      = push_o ? phase_cur + step_q : phase_q;

  always_comb begin
    cfg_o.amp = amp_q;
    if (count_q > hasynth_pkg::COUNT_BITS'(hasynth_pkg::HARMONICS)) begin
      cfg_o.n = hasynth_pkg::COUNT_BITS'(hasynth_pkg::HARMONICS);
    end else begin
      cfg_o.n = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      count_q <= hasynth_pkg::COUNT_BITS'(1);
      amp_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hasynth_pkg::REG_PHASE_STEP: begin
          step_q <= cfg_wdata_i[hasynth_pkg::PHASE_BITS-1:0];
        end
        hasynth_pkg::REG_HARMONIC_COUNT: begin
          count_q <= cfg_wdata_i[hasynth_pkg::COUNT_BITS-1:0];
        end
        hasynth_pkg::REG_WEIGHTS_LO, hasynth_pkg::REG_WEIGHTS_MID,
        hasynth_pkg::REG_WEIGHTS_HI: begin
          for (int h = 0; h < hasynth_pkg::HARMONICS; h++) begin
            if (cfg_idx_i == hasynth_pkg::CFG_IDX_BITS'(hasynth_pkg::REG_WEIGHTS_LO
                + h / hasynth_pkg::AMP_PER_REG)) begin
              amp_q[h] <= cfg_wdata_i[hasynth_pkg::AMP_FIELD_BITS *
                          (h % hasynth_pkg::AMP_PER_REG) +: hasynth_pkg::AMP_BITS];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // a note start leaves the accumulator one step past zero
  a_restart_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && restart_i && !(cfg_we_i && cfg_idx_i == hasynth_pkg::REG_PHASE_STEP))
    |=> phase_q == $past(step_q))
    else $error("phase after restart is not one step");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_o |=> phase_q == $past(phase_q))
    else $error("phase moved without a transaction");

endmodule

// ===== sv/hasynth_queue.sv =====
module hasynth_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hasynth_pkg::phase_t push_phase_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                avail_o,
  output hasynth_pkg::phase_t head_o
);

  hasynth_pkg::phase_t                      mem_q [hasynth_pkg::QUEUE_DEPTH];
  logic [hasynth_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [hasynth_pkg::QUEUE_CNT_BITS-1:0]   count_q, count_d;

  assign full_o  = count_q == hasynth_pkg::QUEUE_CNT_BITS'(hasynth_pkg::QUEUE_DEPTH);
  assign avail_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_phase_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= hasynth_pkg::QUEUE_CNT_BITS'(hasynth_pkg::QUEUE_DEPTH)
    && !(push_i && full_o))
    else $error("queue overflow");

endmodule

// ===== sv/hasynth_cell.sv =====
module hasynth_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                en_i,
  input  logic [hasynth_pkg::AMP_BITS-1:0]    amp_i,
  input  hasynth_pkg::cell_t                  prev_i,
  output hasynth_pkg::cell_t                  next_o
);

  logic [hasynth_pkg::SINE_TABLE_BITS-1:0]  idx;
  logic [hasynth_pkg::QUARTER_BITS:0]       pos;
  logic [hasynth_pkg::AMP_BITS-1:0]         mag;
  logic [2*hasynth_pkg::AMP_BITS-1:0]       prod;
  logic [hasynth_pkg::AMP_BITS-1:0]         scaled;
  logic signed [hasynth_pkg::SAMPLE_BITS-1:0] part;
  hasynth_pkg::cell_t                       next_d, next_q;

  // top bits index the table, second quadrant bit mirrors, top bit negates
  assign idx = prev_i.hphase[hasynth_pkg::PHASE_BITS-1 -: hasynth_pkg::SINE_TABLE_BITS];

  always_comb begin
    if (idx[hasynth_pkg::QUARTER_BITS]) begin
      pos = (hasynth_pkg::QUARTER_BITS+1)'(hasynth_pkg::QUARTER)
            - {1'b0, idx[hasynth_pkg::QUARTER_BITS-1:0]};
    end else begin
      pos = {1'b0, idx[hasynth_pkg::QUARTER_BITS-1:0]};
    end
    mag    = hasynth_pkg::SINE_ROM[pos];
    prod   = (2*hasynth_pkg::AMP_BITS)'(mag) * (2*hasynth_pkg::AMP_BITS)'(amp_i);
    scaled = prod[2*hasynth_pkg::AMP_BITS-1 -: hasynth_pkg::AMP_BITS];
    if (!en_i) begin
      part = '0;
    end else if (idx[hasynth_pkg::SINE_TABLE_BITS-1]) begin
      part = -$signed({1'b0, scaled});
    end else begin
      part = $signed({1'b0, scaled});
    end
  end

  always_comb begin
    next_d.valid  = prev_i.valid;
    next_d.phase  = prev_i.phase;
    next_d.hphase = prev_i.hphase + prev_i.phase;
    next_d.sum    = prev_i.sum + hasynth_pkg::SUM_BITS'(prev_i.part);
    next_d.part   = part;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q <= '0;
    end else if (adv_i) begin
      next_q <= next_d;
    end
  end

  assign next_o = next_q;

endmodule

// ===== sv/hasynth_back.sv =====
module hasynth_back (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  hasynth_pkg::synth_cfg_t                   cfg_i,
  input  logic                                      q_avail_i,
  input  hasynth_pkg::phase_t                       q_head_i,
  output logic                                      pop_o,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic signed [hasynth_pkg::SAMPLE_BITS-1:0] sample_o,
  output logic                                      clipped_o
);

  localparam logic signed [hasynth_pkg::SUM_BITS-1:0] SatMax =
    hasynth_pkg::SUM_BITS'((1 << (hasynth_pkg::SAMPLE_BITS - 1)) - 1);
  localparam logic signed [hasynth_pkg::SUM_BITS-1:0] SatMin = -SatMax - 1'b1;

  hasynth_pkg::cell_t                          chain [hasynth_pkg::HARMONICS+1];
  logic                                        adv;
  logic signed [hasynth_pkg::SUM_BITS-1:0]     total;
  logic                                        out_valid_q;
  logic signed [hasynth_pkg::SAMPLE_BITS-1:0]  sample_q, sample_d;
  logic                                        clipped_q, clipped_d;

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && q_avail_i;

  always_comb begin
    chain[0].valid  = q_avail_i;
    chain[0].phase  = q_head_i;
    chain[0].hphase = q_head_i;
    chain[0].sum    = '0;
    chain[0].part   = '0;
  end

  for (genvar j = 0; j < hasynth_pkg::HARMONICS; j++) begin : g_cell
    hasynth_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .en_i   (hasynth_pkg::COUNT_BITS'(j) < cfg_i.n),
      .amp_i  (cfg_i.amp[j]),
      .prev_i (chain[j]),
      .next_o (chain[j+1])
    );
  end

  assign total = chain[hasynth_pkg::HARMONICS].sum
               + hasynth_pkg::SUM_BITS'(chain[hasynth_pkg::HARMONICS].part);

  always_comb begin
    clipped_d = 1'b0;
    sample_d  = total[hasynth_pkg::SAMPLE_BITS-1:0];
    if (total > SatMax) begin
      sample_d  = SatMax[hasynth_pkg::SAMPLE_BITS-1:0];
      clipped_d = 1'b1;
    end else if (total < SatMin) begin
      sample_d  = SatMin[hasynth_pkg::SAMPLE_BITS-1:0];
      clipped_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain[hasynth_pkg::HARMONICS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sample_q  <= sample_d;
      clipped_q <= clipped_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign clipped_o   = clipped_q;

  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && clipped_q) |->
    (sample_q == SatMax[hasynth_pkg::SAMPLE_BITS-1:0]
     || sample_q == SatMin[hasynth_pkg::SAMPLE_BITS-1:0]))
    else $error("clipped sample not at a rail");

endmodule

// ===== sv/harmonic_additive_synth.sv =====
// an accepted input passes the phase queue, each cell and the output register
// one sample per cycle when not stalled, one harmonic per cell in a 12 cell chain
// a 4 entry phase queue sits between the phase accumulator and the cell chain
// a stalled pending sample holds the whole chain; input stalls only on full queue
// reset: phase 0, phase_step 0, harmonic_count 1, all weights 0, no sample pending
module harmonic_additive_synth (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [hasynth_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [hasynth_pkg::CFG_DATA_BITS-1:0]      cfg_wdata_i,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic                                       restart_i,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic signed [hasynth_pkg::SAMPLE_BITS-1:0] sample_o,
  output logic                                       clipped_o
);

  logic                     push;
  hasynth_pkg::phase_t      push_phase;
  logic                     q_full;
  logic                     pop;
  logic                     q_avail;
  hasynth_pkg::phase_t      q_head;
  hasynth_pkg::synth_cfg_t  cfg;

  hasynth_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_phase_o (push_phase),
    .cfg_o        (cfg)
  );

  hasynth_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_phase_i (push_phase),
    .full_o       (q_full),
    .pop_i        (pop),
    .avail_o      (q_avail),
    .head_o       (q_head)
  );

  hasynth_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_avail_i   (q_avail),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_o    (sample_o),
    .clipped_o   (clipped_o)
  );

endmodule
